// ===== sv/tgp_pkg.sv =====
// Shared types and constants for the turtle grid plotter.
// Depends on nothing; every other file of the block imports it.
package tgp_pkg;

    // Widest row address the block supports (a grid of up to 64 rows).
    localparam int MAX_AW = 6;

    localparam logic [2:0] CMD_PEN_UP    = 3'd0;
    localparam logic [2:0] CMD_PEN_DOWN  = 3'd1;
    localparam logic [2:0] CMD_TURN_RIGHT = 3'd2;
    localparam logic [2:0] CMD_TURN_LEFT = 3'd3;
    localparam logic [2:0] CMD_MOVE      = 3'd4;
    localparam logic [2:0] CMD_SHOW      = 3'd5;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] steps;
    } t_in;

    typedef struct packed {
        logic [5:0]  row_index;
        logic [15:0] row_bits;
        logic [5:0]  pos_x;
        logic [5:0]  pos_y;
        logic [1:0]  heading_out;
        logic        pen_out;
        logic        last;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              accept;
        logic              rd_en;
        logic [MAX_AW-1:0] rd_addr;
        logic              show;
        logic              finish;
    } t_dp_ctl;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic              pen;
        logic              horiz;
        logic [MAX_AW-1:0] lo;
        logic [MAX_AW-1:0] hi;
        logic [MAX_AW-1:0] row;
    } t_dp_stat;

endpackage

// ===== sv/tgp_datapath.sv =====
// Datapath of the turtle grid plotter: turtle state, grid memory with row valid bits,
// read-modify-write marking and the result register. Depends on tgp_pkg.
module tgp_datapath #(
    parameter int GRID = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tgp_pkg::t_in     i_cmd,
    input  tgp_pkg::t_dp_ctl i_ctl,
    output tgp_pkg::t_dp_stat o_stat,
    output logic             o_valid,
    output tgp_pkg::t_out    o_result
);
    import tgp_pkg::*;

    localparam int AW = (GRID > 1) ? $clog2(GRID) : 1;
    localparam int RW = (GRID > 16) ? GRID : 16;
    localparam logic [AW-1:0] EDGE = AW'(GRID - 1);

    logic [AW-1:0]   r_col, n_col;
    logic [AW-1:0]   r_row, n_row;
    logic [1:0]      r_heading, n_heading;
    logic            r_pen, n_pen;
    logic            r_valid, n_valid;
    t_out            r_out, n_out;

    logic            r_horiz;
    logic [AW-1:0]   r_lo, r_hi, r_end;

    logic [GRID-1:0] r_mem [GRID];
    logic [GRID-1:0] r_vld;
    logic [GRID-1:0] r_q;
    logic            r_q_vld;
    logic            r_rd_pend;
    logic            r_rd_show;
    logic [AW-1:0]   r_rd_addr;

    logic            horiz, fwd;
    logic [AW-1:0]   start_pos, end_pos, lo_pos, hi_pos;
    logic [8:0]      fwd_sum;
    logic [GRID-1:0] q_eff, mask;
    logic [RW-1:0]   q_wide;
    logic            wr_en;
    logic [AW-1:0]   rd_addr;

    assign rd_addr = i_ctl.rd_addr[AW-1:0];

    // Plan of a move from the state at acceptance: clamp at the grid edge.
    always_comb begin
        horiz     = ~r_heading[0];
        fwd       = ~r_heading[1];
        start_pos = horiz ? r_col : r_row;
        fwd_sum   = 9'(start_pos) + 9'(i_cmd.steps);
        if (fwd) begin
            end_pos = (fwd_sum > 9'(GRID - 1)) ? EDGE : fwd_sum[AW-1:0];
        end else begin
            end_pos = (i_cmd.steps > 8'(start_pos)) ? '0
                    : AW'(8'(start_pos) - i_cmd.steps);
        end
        lo_pos = (start_pos < end_pos) ? start_pos : end_pos;
        hi_pos = (start_pos < end_pos) ? end_pos : start_pos;
    end

    assign q_eff  = r_q_vld ? r_q : '0;
    assign q_wide = RW'(q_eff);
    assign wr_en  = r_rd_pend & ~r_rd_show;

    always_comb begin
        for (int i = 0; i < GRID; i++) begin
            if (r_horiz) begin
                mask[i] = (AW'(i) >= r_lo) && (AW'(i) <= r_hi);
            end else begin
                mask[i] = (AW'(i) == r_col);
            end
        end
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_heading = r_heading;
        n_pen     = r_pen;
        n_valid   = 1'b0;
        if (i_ctl.accept) begin
            unique case (i_cmd.command)
                CMD_PEN_UP:     n_pen = 1'b0;
                CMD_PEN_DOWN:   n_pen = 1'b1;
                CMD_TURN_RIGHT: n_heading = r_heading + 2'd1;
                CMD_TURN_LEFT:  n_heading = r_heading - 2'd1;
                default:        n_pen = r_pen;
            endcase
            n_valid = (i_cmd.command != CMD_MOVE) && (i_cmd.command != CMD_SHOW);
        end
        if (i_ctl.finish) begin
            if (r_horiz) begin
                n_col = r_end;
            end else begin
                n_row = r_end;
            end
            n_valid = 1'b1;
        end
        n_out.row_index   = '0;
        n_out.row_bits    = '0;
        n_out.pos_x       = 6'(n_col);
        n_out.pos_y       = 6'(n_row);
        n_out.heading_out = n_heading;
        n_out.pen_out     = n_pen;
        n_out.last        = 1'b1;
        if (r_rd_pend && r_rd_show) begin
            n_out.row_index = 6'(r_rd_addr);
            n_out.row_bits  = q_wide[15:0];
            n_out.last      = (r_rd_addr == EDGE);
            n_valid         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_heading <= '0;
            r_pen     <= 1'b0;
            r_valid   <= 1'b0;
            r_vld     <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_heading <= n_heading;
            r_pen     <= n_pen;
            r_valid   <= n_valid;
            r_rd_pend <= i_ctl.rd_en;
            if (wr_en) begin
                r_vld[r_rd_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (i_ctl.accept) begin
            r_horiz <= horiz;
            r_lo    <= lo_pos;
            r_hi    <= hi_pos;
            r_end   <= end_pos;
        end
        if (i_ctl.rd_en) begin
            r_q       <= r_mem[rd_addr];
            r_q_vld   <= r_vld[rd_addr];
            r_rd_addr <= rd_addr;
            r_rd_show <= i_ctl.show;
        end
        if (wr_en) begin
            r_mem[r_rd_addr] <= q_eff | mask;
        end
    end

    assign o_stat.pen   = r_pen;
    assign o_stat.horiz = r_horiz;
    assign o_stat.lo    = MAX_AW'(r_lo);
    assign o_stat.hi    = MAX_AW'(r_hi);
    assign o_stat.row   = MAX_AW'(r_row);
    assign o_valid      = r_valid;
    assign o_result     = r_out;

endmodule

// ===== sv/tgp_ctrl.sv =====
// Controller of the turtle grid plotter: sequences move planning, row sweeps
// for marking and showing, and the move's closing status. Depends on tgp_pkg.
module tgp_ctrl #(
    parameter int GRID = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [2:0]        i_command,
    input  tgp_pkg::t_dp_stat i_stat,
    output tgp_pkg::t_dp_ctl  o_ctl,
    output logic              o_busy
);
    import tgp_pkg::*;

    localparam int AW = (GRID > 1) ? $clog2(GRID) : 1;
    localparam logic [AW-1:0] EDGE = AW'(GRID - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAN,
        S_SWEEP,
        S_DRAIN
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_stop;
    logic          r_show;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_addr  <= '0;
            r_stop  <= '0;
            r_show  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_accept && i_command == CMD_MOVE) begin
                        r_state <= S_PLAN;
                    end else if (i_accept && i_command == CMD_SHOW) begin
                        r_state <= S_SWEEP;
                        r_addr  <= '0;
                        r_stop  <= EDGE;
                        r_show  <= 1'b1;
                    end
                end
                S_PLAN: begin
                    if (i_stat.pen) begin
                        r_state <= S_SWEEP;
                        r_addr  <= i_stat.horiz ? i_stat.row[AW-1:0] : i_stat.lo[AW-1:0];
                        r_stop  <= i_stat.horiz ? i_stat.row[AW-1:0] : i_stat.hi[AW-1:0];
                        r_show  <= 1'b0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    if (r_addr == r_stop) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_DRAIN: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.accept  = i_accept;
    assign o_ctl.rd_en   = (r_state == S_SWEEP);
    assign o_ctl.rd_addr = MAX_AW'(r_addr);
    assign o_ctl.show    = r_show;
    assign o_ctl.finish  = ((r_state == S_PLAN) && !i_stat.pen)
                         || ((r_state == S_DRAIN) && !r_show);
    assign o_busy        = (r_state != S_IDLE);

endmodule

// ===== sv/turtle_grid_plotter_top.sv =====
// Top level of the turtle grid plotter: joins controller and datapath.
// Depends on tgp_pkg, tgp_ctrl and tgp_datapath.
//
// A command is taken at a rising edge where start is high and busy is low. Every
// result appears on o_result for exactly one cycle, flagged by o_valid, and the
// receiver cannot hold it off, so it must take each transfer as it comes. Pen up,
// pen down, turns and unused codes leave busy low, and the status result follows
// in the next cycle, so such commands may arrive back to back. A move with the
// pen up keeps busy high through the plan state only and reports its status as
// busy falls again. A move with the pen down sweeps the rows it touches through
// the grid memory, one read-modify-write per cycle on its single write port: a
// horizontal stroke touches one row, a vertical stroke N rows, and busy stays
// high through the plan, sweep and drain states, the status following as busy
// falls. Show reads every row in turn through the sweep and drain states, and
// one row result comes out per cycle, the last row flagged by last. The grid
// starts cleared after reset without any clearing pass, since each row carries
// a valid bit that reset clears. GRID may range from 2 to 64; row_bits always
// shows columns 0 to 15 of a row.
module turtle_grid_plotter_top #(
    parameter int GRID = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tgp_pkg::t_in  i_cmd,
    output logic          o_valid,
    output tgp_pkg::t_out o_result
);
    import tgp_pkg::*;

    t_dp_ctl  ctl;
    t_dp_stat stat;
    logic     accept;

    // A command transfer completes whenever start meets an idle block.
    assign accept = start & ~busy;

    tgp_ctrl #(
        .GRID(GRID)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_command (i_cmd.command),
        .i_stat    (stat),
        .o_ctl     (ctl),
        .o_busy    (busy)
    );

    tgp_datapath #(
        .GRID(GRID)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

`ifndef SYNTHESIS
    // A command other than move or show gives its status result in the very next cycle.
    a_simple_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.command != CMD_MOVE && i_cmd.command != CMD_SHOW)
        |=> (o_valid && o_result.last))
        else $error("single-cycle command gave no status result");

    // Show occupies the block for the sweep that follows.
    a_show_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.command == CMD_SHOW) |=> busy)
        else $error("show command did not start a row sweep");

    // The only final result carrying a row index other than zero is the last row.
    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.last && o_result.row_index != 6'd0)
        |-> (o_result.row_index == 6'(GRID - 1)))
        else $error("last flag on a row other than the final one");
`endif

endmodule
